// File: rtl/wgs_pkg.sv
// ----------------------------------------------------------------------------
// wgs_pkg
// Shared types and constants of the 3D damped wave grid stencil block.
// ----------------------------------------------------------------------------
package wgs_pkg;

    // default sizes of the grid store and the cell value width
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_DEPTH_DEF  = 16;
    localparam int VALUE_BITS_DEF = 24;

    // wide enough for any grid size up to 256
    localparam int DIM_BITS = 9;
    localparam int MIN_DIM  = 8;

    // port field widths
    localparam int ACT_BITS       = 3;
    localparam int CELL_X_BITS    = 6;
    localparam int CELL_Y_BITS    = 6;
    localparam int CELL_Z_BITS    = 4;
    localparam int SAMPLE_BITS    = 24;
    localparam int IN_TDATA_BITS  = 48;
    localparam int CV_BITS        = 24;
    localparam int INTENS_BITS    = 8;
    localparam int OUT_TDATA_BITS = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 18;
    localparam int GAIN_BITS      = 18;
    localparam int DAMP_BITS      = 16;
    localparam int FRAC_BITS      = 16;

    // configuration reset values
    localparam logic [6:0]           GRID_WIDTH_RST  = 7'd64;
    localparam logic [6:0]           GRID_HEIGHT_RST = 7'd64;
    localparam logic [4:0]           GRID_DEPTH_RST  = 5'd16;
    localparam logic [GAIN_BITS-1:0] GAIN_RST        = 18'd21845;
    localparam logic [DAMP_BITS-1:0] DAMP_RST        = 16'd655;

    // intensity: v*2.5 clipped to 1.0, times 255
    localparam int INT_LIMIT = 26215;
    localparam int INT_SCALE = 1275;
    localparam int INT_SHIFT = 17;
    localparam logic [INTENS_BITS-1:0] INT_FULL = 8'd255;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_ADD      = 3'd0,
        ACT_SPLASH   = 3'd1,
        ACT_SOLID    = 3'd2,
        ACT_STEP     = 3'd3,
        ACT_READ     = 3'd4,
        ACT_CLEAR    = 3'd5,
        ACT_RESERVED = 3'd6
    } act_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_GRID_DEPTH  = 3'd2,
        CFG_GAIN        = 3'd3,
        CFG_DAMPING     = 3'd4
    } cfg_idx_t;

    // neighbour codes, also the read order of a stencil cell
    typedef enum logic [2:0] {
        NB_XM   = 3'd0,
        NB_XP   = 3'd1,
        NB_YM   = 3'd2,
        NB_YP   = 3'd3,
        NB_ZM   = 3'd4,
        NB_ZP   = 3'd5,
        NB_SELF = 3'd6
    } nb_t;

    // stencil cell phases
    localparam int PH_BITS      = 4;
    localparam logic [PH_BITS-1:0] PH_FIRST    = 4'd0;
    localparam logic [PH_BITS-1:0] PH_SUM_INIT = 4'd1;
    localparam logic [PH_BITS-1:0] PH_LAST_RD  = 4'd6;
    localparam logic [PH_BITS-1:0] PH_MUL      = 4'd7;
    localparam logic [PH_BITS-1:0] PH_DIFF     = 4'd8;
    localparam logic [PH_BITS-1:0] PH_DAMP     = 4'd9;
    localparam logic [PH_BITS-1:0] PH_WRITE    = 4'd10;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_INIT_WR,
        DP_CLEAR_WR,
        DP_ADD_RD,
        DP_ADD_WR,
        DP_SPLASH_WR,
        DP_SOLID_WR,
        DP_STEP,
        DP_SWAP,
        DP_READ_RD,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t               op;
        logic [PH_BITS-1:0]   phase;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_BITS-1:0]  action;
        logic                 out_free;
        logic [DIM_BITS-1:0]  dim_w;
        logic [DIM_BITS-1:0]  dim_h;
        logic [DIM_BITS-1:0]  dim_d;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_ADD_RD,
        S_ADD_WR,
        S_SPLASH,
        S_SOLID,
        S_STEP,
        S_SWAP,
        S_READ,
        S_CLEAR,
        S_RESULT
    } state_t;

endpackage

// File: rtl/wgs_ctrl.sv
// ----------------------------------------------------------------------------
// wgs_ctrl
// Sequencer of the wave grid: decodes actions, runs sweeps and stencil loops.
// ----------------------------------------------------------------------------
module wgs_ctrl import wgs_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dp_stat_t              stat,
    output dp_cmd_t               cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]  x_cnt,
    output logic [$clog2(MAX_HEIGHT)-1:0] y_cnt,
    output logic [$clog2(MAX_DEPTH)-1:0]  z_cnt,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+$clog2(MAX_DEPTH):0] sweep_addr
);

    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int ZB = $clog2(MAX_DEPTH);
    localparam int FA = XB + YB + ZB + 1;
    localparam logic [DIM_BITS-1:0] TWO = DIM_BITS'(2);

    state_t             state_reg, state_next;
    logic [PH_BITS-1:0] ph_reg, ph_next;
    logic [XB-1:0]      x_reg, x_next;
    logic [YB-1:0]      y_reg, y_next;
    logic [ZB-1:0]      z_reg, z_next;
    logic [FA-1:0]      swp_reg, swp_next;
    logic               x_last, y_last, z_last, swp_last;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ph_reg    <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            swp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            swp_reg   <= swp_next;
        end
    end

    // loop end tests
    assign x_last   = (DIM_BITS'(x_reg) == stat.dim_w - TWO);
    assign y_last   = (DIM_BITS'(y_reg) == stat.dim_h - TWO);
    assign z_last   = (DIM_BITS'(z_reg) == stat.dim_d - TWO);
    assign swp_last = &swp_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        swp_next   = swp_reg;
        cmd.op     = DP_NOP;
        cmd.phase  = ph_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op   = DP_INIT_WR;
                swp_next = swp_reg + 1'b1;
                if (swp_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ph_next = PH_FIRST;
                unique case (stat.action)
                    ACT_ADD:    state_next = S_ADD_RD;
                    ACT_SPLASH: state_next = S_SPLASH;
                    ACT_SOLID:  state_next = S_SOLID;
                    ACT_STEP:
                    begin
                        state_next = S_STEP;
                        x_next     = XB'(1);
                        y_next     = YB'(1);
                        z_next     = ZB'(1);
                    end
                    ACT_READ:   state_next = S_READ;
                    ACT_CLEAR:
                    begin
                        state_next = S_CLEAR;
                        swp_next   = '0;
                    end
                    default:    state_next = S_RESULT;
                endcase
            end
            S_ADD_RD:
            begin
                cmd.op     = DP_ADD_RD;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.op     = DP_ADD_WR;
                state_next = S_RESULT;
            end
            S_SPLASH:
            begin
                cmd.op = DP_SPLASH_WR;
                if (ph_reg == PH_LAST_RD)
                begin
                    ph_next    = PH_FIRST;
                    state_next = S_RESULT;
                end
                else
                    ph_next = ph_reg + 1'b1;
            end
            S_SOLID:
            begin
                cmd.op     = DP_SOLID_WR;
                state_next = S_RESULT;
            end
            S_STEP:
            begin
                cmd.op = DP_STEP;
                if (ph_reg == PH_WRITE)
                begin
                    ph_next = PH_FIRST;
                    if (!x_last)
                        x_next = x_reg + 1'b1;
                    else
                    begin
                        x_next = XB'(1);
                        if (!y_last)
                            y_next = y_reg + 1'b1;
                        else
                        begin
                            y_next = YB'(1);
                            if (!z_last)
                                z_next = z_reg + 1'b1;
                            else
                                state_next = S_SWAP;
                        end
                    end
                end
                else
                    ph_next = ph_reg + 1'b1;
            end
            S_SWAP:
            begin
                cmd.op     = DP_SWAP;
                state_next = S_RESULT;
            end
            S_READ:
            begin
                cmd.op     = DP_READ_RD;
                state_next = S_RESULT;
            end
            S_CLEAR:
            begin
                cmd.op   = DP_CLEAR_WR;
                swp_next = swp_reg + 1'b1;
                if (swp_last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign x_cnt      = x_reg;
    assign y_cnt      = y_reg;
    assign z_cnt      = z_reg;
    assign sweep_addr = swp_reg;

endmodule

// File: rtl/wgs_dp.sv
// ----------------------------------------------------------------------------
// wgs_dp
// Datapath of the wave grid: field and solid memories, stencil arithmetic,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module wgs_dp import wgs_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [IN_TDATA_BITS-1:0]   in_data,
    input  logic [ACT_BITS-1:0]        in_user,
    input  dp_cmd_t                    cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]  x_cnt,
    input  logic [$clog2(MAX_HEIGHT)-1:0] y_cnt,
    input  logic [$clog2(MAX_DEPTH)-1:0]  z_cnt,
    input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+$clog2(MAX_DEPTH):0] sweep_addr,
    output dp_stat_t                   stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [OUT_TDATA_BITS-1:0]  out_data,
    output logic                       out_user
);

    localparam int XB  = $clog2(MAX_WIDTH);
    localparam int YB  = $clog2(MAX_HEIGHT);
    localparam int ZB  = $clog2(MAX_DEPTH);
    localparam int FA  = XB + YB + ZB + 1;
    localparam int SA  = XB + YB;
    localparam int VB  = VALUE_BITS;
    localparam int SW  = VB + 3;
    localparam int PW  = SW + GAIN_BITS + 1;
    localparam int DVW = VB + 7;
    localparam int MW  = DVW + DAMP_BITS + 1;
    localparam int EW  = VB + 10;
    localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (VB - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
    localparam logic signed [EW-1:0] LIM    = EW'(INT_LIMIT);

    function automatic logic [VB-1:0] sat_val(input logic signed [EW-1:0] v);
        logic [VB-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[VB-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[VB-1:0];
        else
            r = v[VB-1:0];
        return r;
    endfunction

    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] r,
                                                    input logic [DIM_BITS-1:0] mx);
        logic [DIM_BITS-1:0] e;
        if (r < DIM_BITS'(MIN_DIM))
            e = DIM_BITS'(MIN_DIM);
        else if (r > mx)
            e = mx;
        else
            e = r;
        return e;
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] lo,
                                                      input logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] c;
        if (v < lo)
            c = lo;
        else if (v > hi)
            c = hi;
        else
            c = v;
        return c;
    endfunction

    // configuration registers
    logic [6:0]           gw_reg, gh_reg;
    logic [4:0]           gd_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    logic [DAMP_BITS-1:0] damp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= GRID_WIDTH_RST;
            gh_reg   <= GRID_HEIGHT_RST;
            gd_reg   <= GRID_DEPTH_RST;
            gain_reg <= GAIN_RST;
            damp_reg <= DAMP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  gw_reg   <= cfg_data[6:0];
                CFG_GRID_HEIGHT: gh_reg   <= cfg_data[6:0];
                CFG_GRID_DEPTH:  gd_reg   <= cfg_data[4:0];
                CFG_GAIN:        gain_reg <= cfg_data[GAIN_BITS-1:0];
                CFG_DAMPING:     damp_reg <= cfg_data[DAMP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // effective grid size
    logic [DIM_BITS-1:0] dw, dh, dd;
    assign dw = eff_dim(DIM_BITS'(gw_reg), DIM_BITS'(MAX_WIDTH));
    assign dh = eff_dim(DIM_BITS'(gh_reg), DIM_BITS'(MAX_HEIGHT));
    assign dd = eff_dim(DIM_BITS'(gd_reg), DIM_BITS'(MAX_DEPTH));

    // captured item
    logic [ACT_BITS-1:0]           act_reg;
    logic [CELL_X_BITS-1:0]        cx_reg;
    logic [CELL_Y_BITS-1:0]        cy_reg;
    logic [CELL_Z_BITS-1:0]        cz_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic                          flag_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_CAPTURE)
        begin
            act_reg  <= in_user;
            cx_reg   <= in_data[5:0];
            cy_reg   <= in_data[11:6];
            cz_reg   <= in_data[15:12];
            val_reg  <= in_data[39:16];
            flag_reg <= in_data[40];
        end
    end

    // live half
    logic half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= 1'b0;
        else if (cmd.op == DP_SWAP)
            half_reg <= ~half_reg;
    end

    // item coordinates
    logic [DIM_BITS-1:0] cxe, cye, cze;
    logic [DIM_BITS-1:0] ax, ay, az, px, py, pz;
    logic                in_grid, solid_ok;

    assign cxe = DIM_BITS'(cx_reg);
    assign cye = DIM_BITS'(cy_reg);
    assign cze = DIM_BITS'(cz_reg);
    assign ax  = clamp_dim(cxe, DIM_BITS'(2), dw - DIM_BITS'(2));
    assign ay  = clamp_dim(cye, DIM_BITS'(2), dh - DIM_BITS'(2));
    assign az  = clamp_dim(cze, DIM_BITS'(2), dd - DIM_BITS'(2));
    assign px  = clamp_dim(cxe, DIM_BITS'(3), dw - DIM_BITS'(3));
    assign py  = clamp_dim(cye, DIM_BITS'(3), dh - DIM_BITS'(3));
    assign pz  = clamp_dim(cze, DIM_BITS'(3), dd - DIM_BITS'(3));
    assign in_grid  = (cxe < dw) && (cye < dh) && (cze < dd);
    assign solid_ok = (cxe < DIM_BITS'(MAX_WIDTH)) && (cye < DIM_BITS'(MAX_HEIGHT));

    // neighbour addressing for splash and stencil
    logic [XB-1:0] bx, nx;
    logic [YB-1:0] by, ny;
    logic [ZB-1:0] bz, nz;

    always_comb
    begin
        if (cmd.op == DP_SPLASH_WR)
        begin
            bx = px[XB-1:0];
            by = py[YB-1:0];
            bz = pz[ZB-1:0];
        end
        else
        begin
            bx = x_cnt;
            by = y_cnt;
            bz = z_cnt;
        end
        nx = bx;
        ny = by;
        nz = bz;
        unique case (cmd.phase[2:0])
            NB_XM:   nx = bx - 1'b1;
            NB_XP:   nx = bx + 1'b1;
            NB_YM:   ny = by - 1'b1;
            NB_YP:   ny = by + 1'b1;
            NB_ZM:   nz = bz - 1'b1;
            NB_ZP:   nz = bz + 1'b1;
            default: ;
        endcase
    end

    // memories
    logic [VB-1:0]        field_mem [2**FA];
    logic                 solid_mem [2**SA];
    logic signed [VB-1:0] fq_reg;
    logic                 sq_reg;
    logic                 fwe, fre, swe, sre, swd;
    logic [FA-1:0]        fwa, fra;
    logic [SA-1:0]        swa, sra;
    logic [VB-1:0]        fwd;

    always_ff @(posedge clk)
    begin
        if (fwe)
            field_mem[fwa] <= fwd;
        if (fre)
            fq_reg <= field_mem[fra];
    end

    always_ff @(posedge clk)
    begin
        if (swe)
            solid_mem[swa] <= swd;
        if (sre)
            sq_reg <= solid_mem[sra];
    end

    // stencil arithmetic
    logic signed [SW-1:0]  sum_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [VB-1:0]  old_reg;
    logic signed [DVW-1:0] dv_reg;
    logic signed [MW-1:0]  dm_reg;
    logic signed [EW-1:0]  r_full;
    logic [VB-1:0]         r_val;

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_STEP)
        begin
            if (cmd.phase == PH_SUM_INIT)
                sum_reg <= SW'(fq_reg);
            else if (cmd.phase > PH_SUM_INIT && cmd.phase <= PH_LAST_RD)
                sum_reg <= sum_reg + SW'(fq_reg);
            if (cmd.phase == PH_MUL)
            begin
                prod_reg <= sum_reg * $signed({1'b0, gain_reg});
                old_reg  <= fq_reg;
            end
            if (cmd.phase == PH_DIFF)
                dv_reg <= DVW'($signed(prod_reg[PW-1:FRAC_BITS])) - DVW'(old_reg);
            if (cmd.phase == PH_DAMP)
                dm_reg <= dv_reg * $signed({1'b0, damp_reg});
        end
    end

    assign r_full = EW'(dv_reg) - EW'($signed(dm_reg[MW-1:FRAC_BITS]));
    assign r_val  = sq_reg ? '0 : sat_val(r_full);

    // memory port selection
    always_comb
    begin
        fwe = 1'b0;
        fre = 1'b0;
        swe = 1'b0;
        sre = 1'b0;
        fwa = sweep_addr;
        fra = {half_reg, nz, ny, nx};
        fwd = '0;
        swa = sweep_addr[SA-1:0];
        sra = {y_cnt, x_cnt};
        swd = 1'b0;
        unique case (cmd.op)
            DP_INIT_WR:
            begin
                fwe = 1'b1;
                swe = 1'b1;
            end
            DP_CLEAR_WR:
                fwe = 1'b1;
            DP_ADD_RD:
            begin
                fre = 1'b1;
                fra = {half_reg, az[ZB-1:0], ay[YB-1:0], ax[XB-1:0]};
            end
            DP_ADD_WR:
            begin
                fwe = 1'b1;
                fwa = {half_reg, az[ZB-1:0], ay[YB-1:0], ax[XB-1:0]};
                fwd = sat_val(EW'(fq_reg) + EW'(val_reg));
            end
            DP_SPLASH_WR:
            begin
                fwe = 1'b1;
                fwa = {half_reg, nz, ny, nx};
                if (cmd.phase[2:0] == NB_SELF)
                    fwd = sat_val(EW'(val_reg));
                else
                    fwd = sat_val(EW'(val_reg) >>> 1);
            end
            DP_SOLID_WR:
            begin
                swe = solid_ok;
                swa = {cye[YB-1:0], cxe[XB-1:0]};
                swd = flag_reg;
            end
            DP_STEP:
            begin
                if (cmd.phase <= PH_LAST_RD)
                begin
                    fre = 1'b1;
                    if (cmd.phase[2:0] == NB_SELF)
                        fra = {~half_reg, nz, ny, nx};
                end
                sre = (cmd.phase == PH_FIRST);
                if (cmd.phase == PH_WRITE)
                begin
                    fwe = 1'b1;
                    fwa = {~half_reg, z_cnt, y_cnt, x_cnt};
                    fwd = r_val;
                end
            end
            DP_READ_RD:
            begin
                fre = 1'b1;
                fra = {half_reg, cze[ZB-1:0], cye[YB-1:0], cxe[XB-1:0]};
            end
            default: ;
        endcase
    end

    // result
    logic signed [EW-1:0]      rve;
    logic [INTENS_BITS-1:0]    inten;
    logic [25:0]               iprod;
    logic                      is_read;
    logic                      out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;
    logic                      out_user_reg;

    assign rve     = EW'(fq_reg);
    assign is_read = (act_reg == ACT_READ) && in_grid;
    assign iprod   = 26'(rve[14:0]) * 26'(INT_SCALE);

    always_comb
    begin
        if (rve <= EW'(0))
            inten = '0;
        else if (rve >= LIM)
            inten = INT_FULL;
        else
            inten = iprod[INT_SHIFT+INTENS_BITS-1:INT_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == DP_RESULT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_RESULT)
        begin
            out_user_reg <= (act_reg <= ACT_CLEAR);
            if (is_read)
                out_data_reg <= {inten, rve[CV_BITS-1:0]};
            else
                out_data_reg <= '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    assign stat.action   = act_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.dim_w    = dw;
    assign stat.dim_h    = dh;
    assign stat.dim_d    = dd;

endmodule

// File: rtl/wave_grid_3d_stencil_top.sv
// ----------------------------------------------------------------------------
// wave_grid_3d_stencil_top
// Double-buffered 3D damped wave grid with a six-neighbour stencil pass.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: tuser holds the action, tdata the cell
//   coordinates, sample value and solid flag. Each item gives exactly one
//   result item on m_axis: the read cell value, its intensity and a done flag.
//   Configuration is written on cfg_we/cfg_index/cfg_data while idle.
// Sequencing: items run one at a time. In a step, one field memory read port
//   serves the seven reads of every stencil cell; a clear writes all
//   2^(1+log2 MAX_WIDTH+log2 MAX_HEIGHT+log2 MAX_DEPTH) field memory words
//   (131072 at the defaults), one memory word per cycle.
// Reset: all 2^(1+log2 MAX_WIDTH+log2 MAX_HEIGHT+log2 MAX_DEPTH) words of the
//   field memory (131072 at the defaults) and the solid map are swept to zero;
//   s_axis_tready stays low meanwhile, config writes are taken.
// Stall: the result sits in an output register until m_axis_tready; a new
//   item may be accepted meanwhile and its work runs up to its own result.
// ----------------------------------------------------------------------------
module wave_grid_3d_stencil_top import wgs_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // cell_x, cell_y, cell_z, sample_value, solid_flag, zero fill
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // action
    input  logic [ACT_BITS-1:0]       s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // cell_value, intensity
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    // done_res
    output logic                      m_axis_tuser,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int ZB = $clog2(MAX_DEPTH);

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [XB-1:0]       x_cnt;
    logic [YB-1:0]       y_cnt;
    logic [ZB-1:0]       z_cnt;
    logic [XB+YB+ZB:0]   sweep_addr;

    wgs_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .stat       (stat),
        .cmd        (cmd),
        .x_cnt      (x_cnt),
        .y_cnt      (y_cnt),
        .z_cnt      (z_cnt),
        .sweep_addr (sweep_addr)
    );

    wgs_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DEPTH  (MAX_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_data    (s_axis_tdata),
        .in_user    (s_axis_tuser),
        .cmd        (cmd),
        .x_cnt      (x_cnt),
        .y_cnt      (y_cnt),
        .z_cnt      (z_cnt),
        .sweep_addr (sweep_addr),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser)
    );

endmodule

// File: rtl/wgs_chk.sv
// ----------------------------------------------------------------------------
// wgs_chk
// Port-level checks of the wave grid block, bound to the top level.
// ----------------------------------------------------------------------------
module wgs_chk import wgs_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic                      m_axis_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while busy");

    // a reserved action gives an all-zero result
    a_rsvd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero data on a not-done result");

endmodule

bind wave_grid_3d_stencil_top wgs_chk u_wgs_chk (.*);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the 3D damped wave grid: commands are driven with
// random gaps, a scoreboard keeps its own copy of both grid halves and the
// solid map, predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import wgs_pkg::*;

    localparam int CYCLE_LIMIT = 12000000;
    localparam int LONG_HOLD   = 300;

    // ------------------------------------------------------------------------
    // grid predictor and expected result store
    // ------------------------------------------------------------------------
    class wave_grid_scoreboard;
        typedef struct {
            logic [23:0] cell_value;
            logic [7:0]  intensity;
            logic        done_res;
        } grid_result_t;

        int           cells[2][16][64][64];
        bit           solid[64][64];
        bit           live_half;
        int           width_reg;
        int           height_reg;
        int           depth_reg;
        longint       gain;
        longint       damping;
        grid_result_t expected_q[$];
        int           errors;

        function new();
            live_half  = 0;
            width_reg  = 64;
            height_reg = 64;
            depth_reg  = 16;
            gain       = 21845;
            damping    = 655;
            errors     = 0;
        endfunction

        function longint sat24(longint v);
            if (v > 64'sd8388607)
                return 64'sd8388607;
            if (v < -64'sd8388608)
                return -64'sd8388608;
            return v;
        endfunction

        function int eff_dim(int r, int maxv);
            if (r < 8)
                return 8;
            return (r > maxv) ? maxv : r;
        endfunction

        function int clamp(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void set_reg(cfg_idx_t idx, int value);
            case (idx)
                CFG_GRID_WIDTH:  width_reg  = value & 'h7f;
                CFG_GRID_HEIGHT: height_reg = value & 'h7f;
                CFG_GRID_DEPTH:  depth_reg  = value & 'h1f;
                CFG_GAIN:        gain       = value & 'h3ffff;
                CFG_DAMPING:     damping    = value & 'hffff;
                default: ;
            endcase
        endfunction

        // one stencil pass over the interior, then swap halves
        function void run_pass(int w, int h, int d);
            int     c;
            int     n;
            longint s;
            longint p;
            longint dv;
            longint r;
            c = live_half;
            n = c ^ 1;
            for (int z = 1; z + 1 < d; z++)
                for (int y = 1; y + 1 < h; y++)
                    for (int x = 1; x + 1 < w; x++)
                    begin
                        s = longint'(cells[c][z][y][x-1]) + cells[c][z][y][x+1]
                          + cells[c][z][y-1][x] + cells[c][z][y+1][x]
                          + cells[c][z-1][y][x] + cells[c][z+1][y][x];
                        p  = (s * gain) >>> 16;
                        dv = p - cells[n][z][y][x];
                        r  = dv - ((dv * damping) >>> 16);
                        if (solid[y][x])
                            r = 0;
                        cells[n][z][y][x] = int'(sat24(r));
                    end
            live_half = n;
        endfunction

        function void note_item(logic [2:0] act, int x, int y, int z, logic [23:0] raw,
                                bit flag);
            grid_result_t res;
            longint       v;
            int           w;
            int           h;
            int           d;
            int           c;
            int           cx;
            int           cy;
            int           cz;
            int           hv;
            v   = longint'($signed(raw));
            w   = eff_dim(width_reg, 64);
            h   = eff_dim(height_reg, 64);
            d   = eff_dim(depth_reg, 16);
            c   = live_half;
            res = '{24'd0, 8'd0, 1'b1};
            case (act)
                ACT_ADD:
                begin
                    cx = clamp(x, 2, w - 2);
                    cy = clamp(y, 2, h - 2);
                    cz = clamp(z, 2, d - 2);
                    cells[c][cz][cy][cx] = int'(sat24(cells[c][cz][cy][cx] + v));
                end
                ACT_SPLASH:
                begin
                    cx = clamp(x, 3, w - 3);
                    cy = clamp(y, 3, h - 3);
                    cz = clamp(z, 3, d - 3);
                    hv = int'(v >>> 1);
                    cells[c][cz][cy][cx]   = int'(v);
                    cells[c][cz][cy][cx-1] = hv;
                    cells[c][cz][cy][cx+1] = hv;
                    cells[c][cz][cy-1][cx] = hv;
                    cells[c][cz][cy+1][cx] = hv;
                    cells[c][cz-1][cy][cx] = hv;
                    cells[c][cz+1][cy][cx] = hv;
                end
                ACT_SOLID:
                    solid[y][x] = flag;
                ACT_STEP:
                    run_pass(w, h, d);
                ACT_READ:
                begin
                    if (x < w && y < h && z < d)
                    begin
                        v = cells[c][z][y][x];
                        res.cell_value = v[23:0];
                        if (v <= 0)
                            res.intensity = 8'd0;
                        else if (v * 5 >= 131072)
                            res.intensity = 8'd255;
                        else
                            res.intensity = 8'((v * 1275) >>> 17);
                    end
                end
                ACT_CLEAR:
                    foreach (cells[i, j, k, l])
                        cells[i][j][k][l] = 0;
                default:
                    res.done_res = 1'b0;
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_BITS-1:0] tdata, logic tuser);
            grid_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result item with no expected result: tdata %h", tdata);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (tdata[23:0] !== exp_res.cell_value)
            begin
                $error("cell_value expected %h actual %h", exp_res.cell_value, tdata[23:0]);
                errors++;
            end
            if (tdata[31:24] !== exp_res.intensity)
            begin
                $error("intensity expected %0d actual %0d", exp_res.intensity, tdata[31:24]);
                errors++;
            end
            if (tuser !== exp_res.done_res)
            begin
                $error("done_res expected %b actual %b", exp_res.done_res, tuser);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic [ACT_BITS-1:0]       s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tuser;
    logic                      cfg_we;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    wave_grid_scoreboard grid_sb;
    bit                  gaps_on;
    bit                  hold_req;
    int                  cycle_count;

    wave_grid_3d_stencil_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial
    begin : sink_proc
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                stall_left    = gap_len();
            end
        end
    end

    // result compare
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            grid_sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_item(logic [2:0] act, int x, int y, int z, logic [23:0] raw,
                             bit flag);
        int gap;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {7'd0, flag, raw, 4'(z), 6'(y), 6'(x)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        // the block sees only the field bits that were packed
        grid_sb.note_item(act, x & 'h3f, y & 'h3f, z & 'hf, raw, flag);
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (grid_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_BITS'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        grid_sb.set_reg(idx, value);
    endtask

    task automatic set_grid(int w, int h, int d, int g, int dmp);
        wait_idle();
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_GRID_DEPTH, d);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_DAMPING, dmp);
    endtask

    // random command, weighted toward cell traffic with some passes
    task automatic send_random();
        int          r;
        int          w;
        int          h;
        int          d;
        logic [23:0] raw;
        r   = $urandom_range(0, 99);
        w   = grid_sb.eff_dim(grid_sb.width_reg, 64);
        h   = grid_sb.eff_dim(grid_sb.height_reg, 64);
        d   = grid_sb.eff_dim(grid_sb.depth_reg, 16);
        raw = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 'h3ffff));
        if ($urandom_range(0, 1))
            raw = -raw;
        if (r < 28)
            send_item(ACT_ADD, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 15), raw, $urandom_range(0, 1));
        else if (r < 45)
            send_item(ACT_SPLASH, $urandom_range(0, w), $urandom_range(0, h),
                      $urandom_range(0, 15), raw, $urandom_range(0, 1));
        else if (r < 52)
            send_item(ACT_SOLID, $urandom_range(0, w), $urandom_range(0, h),
                      $urandom_range(0, 15), raw, $urandom_range(0, 1));
        else if (r < 62)
            send_item(ACT_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 15), raw, $urandom_range(0, 1));
        else if (r < 97)
            send_item(ACT_READ, $urandom_range(0, w), $urandom_range(0, h),
                      $urandom_range(0, d), raw, $urandom_range(0, 1));
        else
            send_item(ACT_RESERVED | 3'($urandom_range(0, 1)), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 15), raw, 1'b1);
    endtask

    initial
    begin : main_proc
        grid_sb       = new();
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, clamping, saturation, every action
        set_grid(8, 8, 8, 21845, 655);
        send_item(ACT_ADD, 0, 0, 0, 24'h7fffff, 1'b0);
        send_item(ACT_ADD, 0, 0, 0, 24'h7fffff, 1'b0);
        send_item(ACT_ADD, 63, 63, 15, 24'h800000, 1'b1);
        send_item(ACT_ADD, 63, 63, 15, 24'h800000, 1'b1);
        send_item(ACT_READ, 2, 2, 2, 24'd0, 1'b0);
        send_item(ACT_READ, 6, 6, 6, 24'd0, 1'b0);
        send_item(ACT_SPLASH, 0, 0, 0, 24'h800001, 1'b0);
        send_item(ACT_SPLASH, 63, 63, 15, 24'h7fffff, 1'b0);
        send_item(ACT_SPLASH, 4, 3, 4, 24'h000a00, 1'b0);
        send_item(ACT_READ, 3, 3, 3, 24'd0, 1'b0);
        send_item(ACT_READ, 3, 3, 2, 24'd0, 1'b0);
        send_item(ACT_SOLID, 3, 3, 0, 24'd0, 1'b1);
        send_item(ACT_SOLID, 63, 63, 0, 24'd0, 1'b1);
        send_item(ACT_STEP, 0, 0, 0, 24'd0, 1'b0);
        send_item(ACT_READ, 4, 3, 4, 24'd0, 1'b0);
        send_item(ACT_READ, 3, 3, 3, 24'd0, 1'b0);
        send_item(ACT_READ, 9, 0, 0, 24'd0, 1'b0);
        send_item(ACT_READ, 0, 8, 0, 24'd0, 1'b0);
        send_item(ACT_READ, 0, 0, 15, 24'd0, 1'b0);
        send_item(ACT_RESERVED, 5, 5, 5, 24'h123456, 1'b1);
        send_item(3'd7, 5, 5, 5, 24'h654321, 1'b1);
        send_item(ACT_SOLID, 3, 3, 0, 24'd0, 1'b0);
        send_item(ACT_CLEAR, 0, 0, 0, 24'd0, 1'b0);
        send_item(ACT_READ, 4, 3, 4, 24'd0, 1'b0);

        // out-of-range sizes and the largest gain and damping
        set_grid(0, 127, 31, 262143, 65535);
        repeat (10) send_random();
        set_grid(64, 8, 8, 0, 0);
        repeat (8) send_random();
        set_grid(8, 64, 16, 131072, 32768);
        repeat (8) send_random();

        // random body over several small grids, long hold-off early on
        set_grid(8, 8, 8, $urandom_range(0, 262143), $urandom_range(0, 65535));
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        repeat (10) send_random();
        gaps_on = 1'b1;
        repeat (8) send_random();
        set_grid(16, 8, 16, $urandom_range(16384, 40000), $urandom_range(0, 4000));
        repeat (15) send_random();
        set_grid(16, 16, 8, $urandom_range(0, 262143), $urandom_range(0, 65535));
        repeat (15) send_random();

        wait_idle();
        if (grid_sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: wave_grid_3d_stencil_top.f
rtl/wgs_pkg.sv
rtl/wgs_ctrl.sv
rtl/wgs_dp.sv
rtl/wave_grid_3d_stencil_top.sv
rtl/wgs_chk.sv
bench/tb_top.sv
